// ----- rtl/tdffc_pkg.sv -----
// ----------------------------------------------------------------------------
// tdffc_pkg
// Shared types and constants for the touch delta/focus filter with
// affine calibration.
// ----------------------------------------------------------------------------
package tdffc_pkg;

	// Touch sample phase
	typedef enum logic [1:0] {
		PH_NONE  = 2'd0,
		PH_WAIT  = 2'd1,
		PH_VALID = 2'd2,
		PH_DONE  = 2'd3
	} phase_t;

	// What the calibration stage does to the held position
	typedef enum logic [1:0] {
		POS_HOLD  = 2'd0,
		POS_SET   = 2'd1,
		POS_CLEAR = 2'd2
	} pos_op_t;

	// Control group passed from the filter to the calibration stage
	typedef struct packed {
		logic    ready;
		phase_t  phase;
		pos_op_t op;
	} ctl_t;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PRESENT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_A   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_B   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_C   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_D   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_E   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_F   = 3'd6;

	localparam logic [31:0] CAL_ONE = 32'h0001_0000;
	localparam logic [15:0] NO_POS  = 16'h7FFF;

	// Result tdata: ready_res, screen_x, screen_y, phase_out, zero fill
	localparam int unsigned OUT_DATA_W = 40;

endpackage

// ----- rtl/touch_delta_focus_filter_calibrate.sv -----
// ----------------------------------------------------------------------------
// touch_delta_focus_filter_calibrate
// Touch panel delta/focus filter with 16.16 affine calibration.
// ----------------------------------------------------------------------------
// One result per transaction, one transaction per clock while results are
// taken. A poll or query is filtered in the cycle it is accepted (filter
// state is committed then, so the next transaction may follow at once);
// the two calibration multiply-adds run through the product and sum stages.
// The result register and the stage registers in front of it keep taking
// transactions while a result waits, so the input stalls only when all
// three stages are full. The user writes configuration through cfg_we,
// cfg_index and cfg_wdata only while idle; the block does not enforce it.
module touch_delta_focus_filter_calibrate #(
	parameter int unsigned SAMPLE_BITS = 12,
	parameter int unsigned MAX_DELTA   = 2,
	parameter int unsigned MAX_FOCUS   = 4
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// configuration write port
	input  logic                                   cfg_we,
	input  logic [tdffc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tdffc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	// input stream
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// tdata: pen_down, x_sample, y_sample, zero fill
	input  logic [((2*SAMPLE_BITS+1+7)/8)*8-1:0]   s_tdata,
	// tuser: kind
	input  logic                                   s_tuser,
	// result stream
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// tdata: ready_res, screen_x, screen_y, phase_out, zero fill
	output logic [tdffc_pkg::OUT_DATA_W-1:0]       m_tdata
);
	import tdffc_pkg::*;

	localparam int unsigned PAD_W = OUT_DATA_W - 35;

	logic        present_q;
	logic [31:0] cal_a_q, cal_b_q, cal_c_q, cal_d_q, cal_e_q, cal_f_q;

	logic v1_q, v2_q, out_v_q;
	logic out_free, s2_free, adv_s1, adv_s2, accept;

	ctl_t                   ctl_s1;
	logic [SAMPLE_BITS-1:0] x_s1, y_s1;
	logic                   ready_res;
	logic [15:0]            screen_x, screen_y;
	phase_t                 phase_out;
	logic                   pen_down;
	logic [SAMPLE_BITS-1:0] x_sample, y_sample;

	assign pen_down = s_tdata[0];
	assign x_sample = s_tdata[SAMPLE_BITS:1];
	assign y_sample = s_tdata[2*SAMPLE_BITS:SAMPLE_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
			cal_a_q <= CAL_ONE;
			cal_b_q <= '0;
			cal_c_q <= '0;
			cal_d_q <= '0;
			cal_e_q <= CAL_ONE;
			cal_f_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PRESENT: present_q <= cfg_wdata[0];
				REG_CAL_A:   cal_a_q <= cfg_wdata;
				REG_CAL_B:   cal_b_q <= cfg_wdata;
				REG_CAL_C:   cal_c_q <= cfg_wdata;
				REG_CAL_D:   cal_d_q <= cfg_wdata;
				REG_CAL_E:   cal_e_q <= cfg_wdata;
				REG_CAL_F:   cal_f_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// advance each stage when the one after it is empty or moving
	assign out_free = !out_v_q || m_tready;
	assign adv_s2 = v2_q && out_free;
	assign s2_free = !v2_q || out_free;
	assign adv_s1 = v1_q && s2_free;
	assign s_tready = !v1_q || s2_free;
	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (accept || adv_s1)
				v1_q <= accept;
			if (adv_s1 || adv_s2)
				v2_q <= adv_s1;
			if (adv_s2 || (out_v_q && m_tready))
				out_v_q <= adv_s2;
		end
	end

	tdffc_filter #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_DELTA   (MAX_DELTA),
		.MAX_FOCUS   (MAX_FOCUS)
	) u_filter (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.present  (present_q),
		.kind     (s_tuser),
		.pen_down (pen_down),
		.x_sample (x_sample),
		.y_sample (y_sample),
		.ctl_s1   (ctl_s1),
		.x_s1     (x_s1),
		.y_s1     (y_s1)
	);

	tdffc_affine #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_affine (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv_s1    (adv_s1),
		.adv_s2    (adv_s2),
		.ctl_s1    (ctl_s1),
		.x_s1      (x_s1),
		.y_s1      (y_s1),
		.cal_a     (cal_a_q),
		.cal_b     (cal_b_q),
		.cal_c     (cal_c_q),
		.cal_d     (cal_d_q),
		.cal_e     (cal_e_q),
		.cal_f     (cal_f_q),
		.ready_res (ready_res),
		.screen_x  (screen_x),
		.screen_y  (screen_y),
		.phase_out (phase_out)
	);

	assign m_tvalid = out_v_q;
	assign m_tdata = {{PAD_W{1'b0}}, 2'(phase_out), screen_y, screen_x, ready_res};

endmodule

// ----- rtl/tdffc_filter.sv -----
// ----------------------------------------------------------------------------
// tdffc_filter
// Phase tracking, delta prediction filter and focus snap. Commits the
// filter state on every accepted transaction and registers the point and
// control for the calibration stage.
// ----------------------------------------------------------------------------
module tdffc_filter #(
	parameter int unsigned SAMPLE_BITS = 12,
	parameter int unsigned MAX_DELTA   = 2,
	parameter int unsigned MAX_FOCUS   = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic                   present,
	input  logic                   kind,
	input  logic                   pen_down,
	input  logic [SAMPLE_BITS-1:0] x_sample,
	input  logic [SAMPLE_BITS-1:0] y_sample,
	output tdffc_pkg::ctl_t        ctl_s1,
	output logic [SAMPLE_BITS-1:0] x_s1,
	output logic [SAMPLE_BITS-1:0] y_s1
);
	import tdffc_pkg::*;

	localparam int unsigned PW = SAMPLE_BITS + 3;
	localparam int unsigned FW = SAMPLE_BITS + 2;
	localparam logic signed [PW-1:0] MD_P = PW'(MAX_DELTA);
	localparam logic signed [PW-1:0] MD_N = -MD_P;
	localparam logic signed [FW-1:0] MF_P = FW'(MAX_FOCUS);
	localparam logic signed [FW-1:0] MF_N = -MF_P;

	phase_t                 phase_q, phase_n;
	logic [SAMPLE_BITS-1:0] hx1_q, hx2_q, hy1_q, hy2_q;
	logic [SAMPLE_BITS-1:0] hx1_n, hx2_n, hy1_n, hy2_n;
	logic [SAMPLE_BITS-1:0] fx_q, fy_q, fx_n, fy_n;
	logic [SAMPLE_BITS-1:0] px_pt, py_pt;
	logic signed [PW-1:0]   pred_x, pred_y, dx, dy;
	logic signed [FW-1:0]   fdx, fdy;
	logic                   near_pred, near_focus, do_read;
	ctl_t                   ctl_n;

	always_comb begin
		pred_x = $signed({2'b00, hx1_q, 1'b0}) - $signed({3'b000, hx2_q});
		pred_y = $signed({2'b00, hy1_q, 1'b0}) - $signed({3'b000, hy2_q});
		dx = pred_x - $signed({3'b000, x_sample});
		dy = pred_y - $signed({3'b000, y_sample});
		fdx = $signed({2'b00, fx_q}) - $signed({2'b00, x_sample});
		fdy = $signed({2'b00, fy_q}) - $signed({2'b00, y_sample});
		near_pred = (dx >= MD_N) && (dx <= MD_P) && (dy >= MD_N) && (dy <= MD_P);
		near_focus = (fdx >= MF_N) && (fdx <= MF_P) && (fdy >= MF_N) && (fdy <= MF_P);
	end

	always_comb begin
		phase_n = phase_q;
		hx1_n = hx1_q;
		hx2_n = hx2_q;
		hy1_n = hy1_q;
		hy2_n = hy2_q;
		fx_n = fx_q;
		fy_n = fy_q;
		px_pt = x_sample;
		py_pt = y_sample;
		ctl_n.ready = 1'b0;
		ctl_n.op = POS_HOLD;

		// queries always read; polls only with the panel present, pen down and a phase other than done
		do_read = kind || (present && pen_down && (phase_q != PH_DONE));

		if (do_read) begin
			case (phase_q)
				PH_NONE: phase_n = PH_WAIT;
				PH_WAIT: begin
					if (near_pred) begin
						if (near_focus) begin
							px_pt = fx_q;
							py_pt = fy_q;
						end else begin
							fx_n = x_sample;
							fy_n = y_sample;
						end
						ctl_n.op = POS_SET;
						phase_n = PH_VALID;
					end else begin
						hx2_n = hx1_q;
						hy2_n = hy1_q;
						hx1_n = x_sample;
						hy1_n = y_sample;
					end
				end
				default: ;
			endcase
		end

		// pen lifted after processing: rearm and drop the position
		if (!kind && present && !pen_down && (phase_q == PH_DONE)) begin
			phase_n = PH_NONE;
			ctl_n.op = POS_CLEAR;
		end

		if (kind && (phase_n == PH_VALID)) begin
			phase_n = PH_NONE;
			ctl_n.ready = 1'b1;
		end

		ctl_n.phase = phase_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DONE;
			hx1_q <= '0;
			hx2_q <= '0;
			hy1_q <= '0;
			hy2_q <= '0;
			fx_q <= '0;
			fy_q <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			hx1_q <= hx1_n;
			hx2_q <= hx2_n;
			hy1_q <= hy1_n;
			hy2_q <= hy2_n;
			fx_q <= fx_n;
			fy_q <= fy_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl_n;
			x_s1 <= px_pt;
			y_s1 <= py_pt;
		end
	end

endmodule

// ----- rtl/tdffc_affine.sv -----
// ----------------------------------------------------------------------------
// tdffc_affine
// 16.16 affine calibration: four products in one stage, sums and the held
// screen position in the next, which also forms the result register.
// ----------------------------------------------------------------------------
module tdffc_affine #(
	parameter int unsigned SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv_s1,
	input  logic                   adv_s2,
	input  tdffc_pkg::ctl_t        ctl_s1,
	input  logic [SAMPLE_BITS-1:0] x_s1,
	input  logic [SAMPLE_BITS-1:0] y_s1,
	input  logic [31:0]            cal_a,
	input  logic [31:0]            cal_b,
	input  logic [31:0]            cal_c,
	input  logic [31:0]            cal_d,
	input  logic [31:0]            cal_e,
	input  logic [31:0]            cal_f,
	output logic                   ready_res,
	output logic [15:0]            screen_x,
	output logic [15:0]            screen_y,
	output tdffc_pkg::phase_t      phase_out
);
	import tdffc_pkg::*;

	ctl_t        ctl_s2;
	logic [31:0] pax_s2, pby_s2, pdx_s2, pey_s2;
	logic [31:0] acc_x, acc_y;
	logic [15:0] pos_x_q, pos_y_q, pos_x_n, pos_y_n;

	// products wrap to 32 bits, as does the whole multiply-add
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ctl_s2 <= ctl_s1;
			pax_s2 <= 32'(cal_a * 32'(x_s1));
			pby_s2 <= 32'(cal_b * 32'(y_s1));
			pdx_s2 <= 32'(cal_d * 32'(x_s1));
			pey_s2 <= 32'(cal_e * 32'(y_s1));
		end
	end

	always_comb begin
		acc_x = pax_s2 + pby_s2 + cal_c;
		acc_y = pdx_s2 + pey_s2 + cal_f;
		pos_x_n = pos_x_q;
		pos_y_n = pos_y_q;
		case (ctl_s2.op)
			POS_SET: begin
				pos_x_n = acc_x[31:16];
				pos_y_n = acc_y[31:16];
			end
			POS_CLEAR: begin
				pos_x_n = NO_POS;
				pos_y_n = NO_POS;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= NO_POS;
			pos_y_q <= NO_POS;
		end else if (adv_s2) begin
			pos_x_q <= pos_x_n;
			pos_y_q <= pos_y_n;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			ready_res <= ctl_s2.ready;
			phase_out <= ctl_s2.phase;
			screen_x <= pos_x_n;
			screen_y <= pos_y_n;
		end
	end

endmodule

// ----- tb/sv/touch_delta_focus_filter_calibrate_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_delta_focus_filter_calibrate_chk
// Watches the configuration port and both stream channels, keeps its own
// copy of the touch filter state and calibration, predicts each result at
// input acceptance and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module touch_delta_focus_filter_calibrate_chk (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tdffc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tdffc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	// tdata: pen_down, x_sample, y_sample, zero fill
	input  logic [31:0]                         s_tdata,
	// tuser: kind
	input  logic                                s_tuser,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	// tdata: ready_res, screen_x, screen_y, phase_out, zero fill
	input  logic [tdffc_pkg::OUT_DATA_W-1:0]    m_tdata,
	output int unsigned                         fail_count,
	output int unsigned                         pending
);
	import tdffc_pkg::*;

	localparam int MAX_DELTA = 2;
	localparam int MAX_FOCUS = 4;

	typedef struct packed {
		logic        ready;
		logic [15:0] sx;
		logic [15:0] sy;
		phase_t      ph;
	} touch_res_t;

	touch_res_t touch_due_q[$];

	// filter state
	phase_t      ph;
	logic [11:0] prev1_x, prev2_x, prev1_y, prev2_y;
	logic [11:0] focus_x, focus_y;
	logic [15:0] scr_x, scr_y;

	// calibration and panel presence
	logic        panel_on;
	logic [31:0] k_xx, k_xy, k_x0, k_yx, k_yy, k_y0;

	int unsigned n_fail = 0;
	int unsigned n_res = 0;

	// 16.16 multiply-add with 32-bit wrap; keep bits 31..16
	function automatic logic [15:0] cal_map(input logic [31:0] kx, input logic [31:0] ky,
			input logic [31:0] k0, input logic [11:0] x, input logic [11:0] y);
		logic [31:0] acc;
		acc = kx * {20'd0, x} + ky * {20'd0, y} + k0;
		return acc[31:16];
	endfunction

	function automatic void filter_read(input logic [11:0] xs, input logic [11:0] ys);
		int dx, dy;
		logic [11:0] ux, uy;
		if (ph == PH_VALID || ph == PH_DONE)
			return;
		if (ph == PH_NONE) begin
			ph = PH_WAIT;
			return;
		end
		dx = 2 * int'(prev1_x) - int'(prev2_x) - int'(xs);
		dy = 2 * int'(prev1_y) - int'(prev2_y) - int'(ys);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		if (dx <= MAX_DELTA && dy <= MAX_DELTA) begin
			dx = int'(focus_x) - int'(xs);
			dy = int'(focus_y) - int'(ys);
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			if (dx <= MAX_FOCUS && dy <= MAX_FOCUS) begin
				// snap to the held focus point
				ux = focus_x;
				uy = focus_y;
			end else begin
				focus_x = xs;
				focus_y = ys;
				ux = xs;
				uy = ys;
			end
			ph = PH_VALID;
			scr_x = cal_map(k_xx, k_xy, k_x0, ux, uy);
			scr_y = cal_map(k_yx, k_yy, k_y0, ux, uy);
		end else begin
			prev2_x = prev1_x;
			prev2_y = prev1_y;
			prev1_x = xs;
			prev1_y = ys;
			ph = PH_WAIT;
		end
	endfunction

	function automatic touch_res_t predict_touch(input logic is_query, input logic pen,
			input logic [11:0] xs, input logic [11:0] ys);
		touch_res_t r;
		r.ready = 1'b0;
		if (!is_query) begin
			if (panel_on) begin
				if (pen && ph != PH_DONE)
					filter_read(xs, ys);
				if (!pen && ph == PH_DONE) begin
					ph = PH_NONE;
					scr_x = NO_POS;
					scr_y = NO_POS;
				end
			end
		end else begin
			filter_read(xs, ys);
			if (ph == PH_VALID) begin
				ph = PH_NONE;
				r.ready = 1'b1;
			end
		end
		r.sx = scr_x;
		r.sy = scr_y;
		r.ph = ph;
		return r;
	endfunction

	task automatic note_fail(input string msg);
		if (n_fail < 10)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		n_fail++;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		touch_res_t got, want;
		if (!arst_n) begin
			ph = PH_DONE;
			prev1_x = '0;
			prev2_x = '0;
			prev1_y = '0;
			prev2_y = '0;
			focus_x = '0;
			focus_y = '0;
			scr_x = NO_POS;
			scr_y = NO_POS;
			panel_on = 1'b0;
			k_xx = CAL_ONE;
			k_xy = '0;
			k_x0 = '0;
			k_yx = '0;
			k_yy = CAL_ONE;
			k_y0 = '0;
			touch_due_q.delete();
			pending <= 0;
			fail_count <= n_fail;
		end else begin
			if (m_tvalid && m_tready) begin
				got.ready = m_tdata[0];
				got.sx = m_tdata[16:1];
				got.sy = m_tdata[32:17];
				got.ph = phase_t'(m_tdata[34:33]);
				if (touch_due_q.size() == 0) begin
					note_fail($sformatf("result %0d arrived with nothing outstanding", n_res));
				end else begin
					want = touch_due_q.pop_front();
					if (got.ready !== want.ready || got.sx !== want.sx ||
							got.sy !== want.sy || got.ph !== want.ph)
						note_fail($sformatf({"result %0d exp/got: ready %0b/%0b x %0d/%0d ",
							"y %0d/%0d phase %0d/%0d"}, n_res, want.ready, got.ready,
							$signed(want.sx), $signed(got.sx), $signed(want.sy),
							$signed(got.sy), want.ph, got.ph));
				end
				n_res++;
			end
			if (s_tvalid && s_tready)
				touch_due_q.push_back(predict_touch(s_tuser, s_tdata[0], s_tdata[12:1],
					s_tdata[24:13]));
			if (cfg_we) begin
				case (cfg_index)
				REG_PRESENT: panel_on = cfg_wdata[0];
				REG_CAL_A: k_xx = cfg_wdata;
				REG_CAL_B: k_xy = cfg_wdata;
				REG_CAL_C: k_x0 = cfg_wdata;
				REG_CAL_D: k_yx = cfg_wdata;
				REG_CAL_E: k_yy = cfg_wdata;
				REG_CAL_F: k_y0 = cfg_wdata;
				default: ;
				endcase
			end
			pending <= touch_due_q.size();
			fail_count <= n_fail;
		end
	end

endmodule

// ----- tb/sv/touch_delta_focus_filter_calibrate_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_delta_focus_filter_calibrate_tb
// Drives polls and consume queries into the touch filter: a directed opening,
// then pen strokes along straight lines with jitter mixed with random noise,
// over several calibration settings and random idling on both channels.
// ----------------------------------------------------------------------------
module touch_delta_focus_filter_calibrate_tb;
	import tdffc_pkg::*;

	localparam int unsigned LATENCY      = 2;
	localparam int unsigned LIMIT_CYCLES = 1000000;
	localparam int unsigned PHASES       = 8;
	localparam int unsigned PHASE_ITEMS  = 220;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam logic        KIND_POLL    = 1'b0;
	localparam logic        KIND_QUERY   = 1'b1;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_wdata;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [31:0]               s_tdata;
	logic                      s_tuser;
	logic                      m_tvalid;
	logic                      m_tready;
	logic [OUT_DATA_W-1:0]     m_tdata;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned cycles;
	int unsigned sent;
	bit          tx_burst;
	bit          rx_hold;

	touch_delta_focus_filter_calibrate dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	touch_delta_focus_filter_calibrate_chk u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// mostly short idles, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int jitter();
		if ($urandom_range(0, 9) < 7)
			return 0;
		return int'($urandom_range(0, 2)) - 1;
	endfunction

	function automatic int pin12(input int v);
		if (v < 0)
			return 0;
		if (v > 4095)
			return 4095;
		return v;
	endfunction

	task automatic send_item(input logic kind, input logic pen, input logic [11:0] x,
			input logic [11:0] y);
		int gap;
		gap = (tx_burst || rx_hold) ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {7'd0, y, x, pen};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
	endtask

	// drop valid and wait until every result is out and the pipe is empty
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// caller lowers cfg_we after the last write of a batch
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic load_cal_set(input int p);
		logic [31:0] ka, kb, kc, kd, ke, kf;
		logic on;
		on = 1'b1;
		ka = CAL_ONE;
		kb = '0;
		kc = '0;
		kd = '0;
		ke = CAL_ONE;
		kf = '0;
		case (p)
		1: begin
			ka = 32'h7FFF_FFFF; kb = 32'h7FFF_FFFF; kc = 32'h7FFF_FFFF;
			kd = 32'h7FFF_FFFF; ke = 32'h7FFF_FFFF; kf = 32'h7FFF_FFFF;
		end
		2: begin
			ka = 32'h8000_0000; kb = 32'h8000_0000; kc = 32'h8000_0000;
			kd = 32'h8000_0000; ke = 32'h8000_0000; kf = 32'h8000_0000;
		end
		3: begin
			// panel absent: only queries move the filter
			on = 1'b0;
			ka = $urandom; kb = $urandom; kc = $urandom;
			kd = $urandom; ke = $urandom; kf = $urandom;
		end
		4: begin
			ka = '0; ke = '0;
		end
		5: begin
			ka = CAL_ONE + $urandom_range(0, 8191) - 4096;
			kb = $urandom_range(0, 2047) - 1024;
			kc = $urandom;
			kd = $urandom_range(0, 2047) - 1024;
			ke = CAL_ONE + $urandom_range(0, 8191) - 4096;
			kf = $urandom;
		end
		6: begin
			ka = 32'hFFFF_0000; ke = 32'hFFFF_0000;
			kc = 32'h7FFF_0000; kf = 32'h8000_0000;
		end
		7: begin
			ka = $urandom; kb = $urandom; kc = $urandom;
			kd = $urandom; ke = $urandom; kf = $urandom;
		end
		default: ;
		endcase
		write_reg(REG_PRESENT, {31'd0, on});
		write_reg(REG_CAL_A, ka);
		write_reg(REG_CAL_B, kb);
		write_reg(REG_CAL_C, kc);
		write_reg(REG_CAL_D, kd);
		write_reg(REG_CAL_E, ke);
		write_reg(REG_CAL_F, kf);
		cfg_we <= 1'b0;
	endtask

	// line of samples with a little jitter, mixed with stray polls and queries, ended by a consume query
	task automatic run_stroke();
		int len, i, x0, y0, vx, vy, cx, cy, r;
		len = $urandom_range(3, 14);
		x0 = $urandom_range(0, 4095);
		y0 = $urandom_range(0, 4095);
		if ($urandom_range(0, 1)) begin
			vx = int'($urandom_range(0, 2)) - 1;
			vy = int'($urandom_range(0, 2)) - 1;
		end else begin
			vx = int'($urandom_range(0, 24)) - 12;
			vy = int'($urandom_range(0, 24)) - 12;
		end
		cx = x0;
		cy = y0;
		tx_burst = ($urandom_range(0, 4) == 0);
		for (i = 0; i < len; i++) begin
			cx = pin12(x0 + vx * i + jitter());
			cy = pin12(y0 + vy * i + jitter());
			r = $urandom_range(0, 99);
			if (r < 70)
				send_item(KIND_POLL, 1'b1, 12'(cx), 12'(cy));
			else if (r < 85)
				send_item(KIND_QUERY, 1'($urandom_range(0, 1)), 12'(cx), 12'(cy));
			else if (r < 92)
				send_item(KIND_POLL, 1'b0, 12'(cx), 12'(cy));
			else
				send_item(KIND_POLL, 1'b1, 12'($urandom_range(0, 4095)),
					12'($urandom_range(0, 4095)));
		end
		send_item(KIND_QUERY, 1'($urandom_range(0, 1)), 12'(cx), 12'(cy));
		tx_burst = 1'b0;
	endtask

	task automatic run_directed();
		// panel absent and processed phase after reset
		send_item(KIND_POLL, 1'b1, 12'd4095, 12'd0);
		send_item(KIND_QUERY, 1'b0, 12'd0, 12'd4095);
		settle();
		write_reg(REG_PRESENT, 32'd1);
		cfg_we <= 1'b0;
		send_item(KIND_POLL, 1'b1, 12'd100, 12'd100);
		send_item(KIND_POLL, 1'b0, 12'd0, 12'd0);
		send_item(KIND_POLL, 1'b1, 12'd0, 12'd0);
		// fill the history, then land on the prediction
		send_item(KIND_POLL, 1'b1, 12'd4095, 12'd4095);
		send_item(KIND_POLL, 1'b1, 12'd4095, 12'd4095);
		send_item(KIND_POLL, 1'b1, 12'd4095, 12'd4095);
		send_item(KIND_POLL, 1'b1, 12'd10, 12'd10);
		send_item(KIND_POLL, 1'b0, 12'd10, 12'd10);
		send_item(KIND_QUERY, 1'b0, 12'd0, 12'd0);
		send_item(KIND_QUERY, 1'b1, 12'd0, 12'd0);
		// within delta and within focus: snaps to the held point
		send_item(KIND_QUERY, 1'b0, 12'd4094, 12'd4093);
		send_item(KIND_QUERY, 1'b0, 12'd0, 12'd0);
		// just outside delta, then a new focus point
		send_item(KIND_POLL, 1'b1, 12'd4092, 12'd4095);
		send_item(KIND_POLL, 1'b1, 12'd4089, 12'd4095);
		send_item(KIND_QUERY, 1'b1, 12'd0, 12'd0);
		send_item(KIND_QUERY, 1'b1, 12'd0, 12'd0);
		send_item(KIND_QUERY, 1'b1, 12'd0, 12'd0);
		send_item(KIND_POLL, 1'b1, 12'd0, 12'd4095);
		send_item(KIND_POLL, 1'b1, 12'd4095, 12'd0);
		send_item(KIND_QUERY, 1'b0, 12'd0, 12'd0);
	endtask

	initial begin : sink
		int n;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold) begin
				// long hold-off so the pipe fills and the input stalls
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
				n = idle_len();
				if (n > 0) begin
					m_tready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
		end
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("** touch_delta_focus_filter_calibrate: FAILED **");
		$finish;
	end

	initial begin : stim
		int p;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_PRESENT;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_POLL;
		tx_burst = 1'b0;
		rx_hold = 1'b0;
		sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (p = 0; p < PHASES; p++) begin
			settle();
			load_cal_set(p);
			if (p == 5)
				rx_hold = 1'b1;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 3) != 0)
					run_stroke();
				else
					send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
			end
		end
		settle();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("** touch_delta_focus_filter_calibrate: PASSED **");
		else
			$display("** touch_delta_focus_filter_calibrate: FAILED **");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/tdffc_pkg.sv
rtl/tdffc_filter.sv
rtl/tdffc_affine.sv
rtl/touch_delta_focus_filter_calibrate.sv
tb/sv/touch_delta_focus_filter_calibrate_chk.sv
tb/sv/touch_delta_focus_filter_calibrate_tb.sv
